// ===== rtl/sast_pkg.sv =====
// ----------------------------------------------------------------------------
// sast_pkg: shared types for the segment/rectangle slab test
// Holds the record that travels from the classify front to the slab back end.
// ----------------------------------------------------------------------------
package sast_pkg;

  // Per-axis flags for the fractions n/d with d >= 0 (d = 0 on a zero-direction
  // axis); the modules size the fractions from COORD_BITS (16-bit default).
  typedef struct packed {
    logic endpoint_in; // an endpoint lies inside the rectangle
    logic x_zero;      // x direction is zero
    logic y_zero;      // y direction is zero
    logic x_pass;      // zero-direction axis: start inside the slab
    logic y_pass;
  } sast_cls_t;

endpackage

// ===== rtl/sast_front.sv =====
// ----------------------------------------------------------------------------
// sast_front: classify stage
// Computes endpoint containment, slab fractions per axis, and registers them.
// ----------------------------------------------------------------------------
module sast_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic        [COORD_BITS-2:0] bw,
  input  logic        [COORD_BITS-2:0] bh,
  output logic                         f_valid,
  input  logic                         f_stall,
  output sast_pkg::sast_cls_t          f_cls,
  output logic signed [COORD_BITS+1:0] f_xlo_n,
  output logic signed [COORD_BITS+1:0] f_xhi_n,
  output logic        [COORD_BITS:0]   f_xd,
  output logic signed [COORD_BITS+1:0] f_ylo_n,
  output logic signed [COORD_BITS+1:0] f_yhi_n,
  output logic        [COORD_BITS:0]   f_yd
);
  import sast_pkg::*;
  localparam int W = COORD_BITS + 2;

  logic signed [W-1:0] sxw, syw, exw, eyw, x0, y0, x1, y1, dx, dy;
  logic in_s, in_e;
  sast_cls_t cls;
  logic signed [W-1:0] xlo, xhi, ylo, yhi;
  logic [COORD_BITS:0] xd, yd;

  logic f_valid_r;
  sast_cls_t cls_r;
  logic signed [W-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic [COORD_BITS:0] xd_r, yd_r;

  always_comb begin
    sxw = W'(sx); syw = W'(sy); exw = W'(ex); eyw = W'(ey);
    x0 = W'(bx); y0 = W'(by);
    x1 = x0 + W'({1'b0, bw});
    y1 = y0 + W'({1'b0, bh});
    dx = exw - sxw;
    dy = eyw - syw;
    in_s = (x0 <= sxw) && (sxw <= x1) && (y0 <= syw) && (syw <= y1);
    in_e = (x0 <= exw) && (exw <= x1) && (y0 <= eyw) && (eyw <= y1);
    cls.endpoint_in = in_s || in_e;
    cls.x_zero = (dx == '0);
    cls.y_zero = (dy == '0);
    cls.x_pass = (x0 <= sxw) && (sxw <= x1);
    cls.y_pass = (y0 <= syw) && (syw <= y1);
    if (dx[W-1]) begin
      xlo = sxw - x1; xhi = sxw - x0; xd = (COORD_BITS+1)'(-dx);
    end else begin
      xlo = x0 - sxw; xhi = x1 - sxw; xd = (COORD_BITS+1)'(dx);
    end
    if (dy[W-1]) begin
      ylo = syw - y1; yhi = syw - y0; yd = (COORD_BITS+1)'(-dy);
    end else begin
      ylo = y0 - syw; yhi = y1 - syw; yd = (COORD_BITS+1)'(dy);
    end
  end

  // Hold the register while the queue pushes back.
  assign in_stall = f_valid_r && f_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (!in_stall) begin
      f_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      cls_r <= cls;
      xlo_r <= xlo; xhi_r <= xhi; xd_r <= xd;
      ylo_r <= ylo; yhi_r <= yhi; yd_r <= yd;
    end
  end

  assign f_valid = f_valid_r;
  assign f_cls   = cls_r;
  assign f_xlo_n = xlo_r;
  assign f_xhi_n = xhi_r;
  assign f_xd    = xd_r;
  assign f_ylo_n = ylo_r;
  assign f_yhi_n = yhi_r;
  assign f_yd    = yd_r;
endmodule

// ===== rtl/sast_queue.sv =====
// ----------------------------------------------------------------------------
// sast_queue: two-entry queue between front and back
// Decouples the two sides; a stalled reader blocks the writer only once both entries are full.
// ----------------------------------------------------------------------------
module sast_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1)) else $error("push lost");
endmodule

// ===== rtl/sast_back.sv =====
// ----------------------------------------------------------------------------
// sast_back: slab evaluation
// Picks entry/exit fractions with registered cross products, then decides.
// ----------------------------------------------------------------------------
module sast_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_stall,
  input  sast_pkg::sast_cls_t          q_cls,
  input  logic signed [COORD_BITS+1:0] q_xlo_n,
  input  logic signed [COORD_BITS+1:0] q_xhi_n,
  input  logic        [COORD_BITS:0]   q_xd,
  input  logic signed [COORD_BITS+1:0] q_ylo_n,
  input  logic signed [COORD_BITS+1:0] q_yhi_n,
  input  logic        [COORD_BITS:0]   q_yd,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic                         out_endpoint_inside
);
  import sast_pkg::*;
  localparam int W  = COORD_BITS + 2;
  localparam int PW = 2 * W + 1;

  // Stage 1 registers: cross products for lo and hi selection.
  logic v1_r;
  sast_cls_t c1_r;
  logic signed [W-1:0] xlo1_r, xhi1_r, ylo1_r, yhi1_r;
  logic [COORD_BITS:0] xd1_r, yd1_r;
  logic signed [PW-1:0] pl_x_r, pl_y_r, ph_x_r, ph_y_r;
  // Stage 2 registers: chosen lo/hi and their cross products.
  logic v2_r;
  sast_cls_t c2_r;
  logic signed [W-1:0] lon2_r, hin2_r;
  logic [COORD_BITS:0] lod2_r, hid2_r;
  logic signed [PW-1:0] a2_r, b2_r;
  // Output register.
  logic ov_r, hit_r, ins_r;

  logic adv, adv1, adv2;
  logic signed [W-1:0] lon, hin;
  logic [COORD_BITS:0] lod, hid;
  logic lo_le_hi, slab_hit, hit_c;
  logic signed [W-1:0] tn;
  logic [COORD_BITS:0] td;

  assign adv  = !ov_r || !out_stall;
  assign adv2 = adv || !v2_r;
  assign adv1 = adv2 || !v1_r;
  assign q_stall = !adv1;

  always_comb begin
    // lo = larger lo; hi = smaller hi, x wins ties; a zero-direction axis is skipped
    if (c1_r.x_zero) begin
      lon = ylo1_r; lod = yd1_r;
      hin = yhi1_r; hid = yd1_r;
    end else if (c1_r.y_zero) begin
      lon = xlo1_r; lod = xd1_r;
      hin = xhi1_r; hid = xd1_r;
    end else begin
      // ylo/yd > xlo/xd  <=>  ylo*xd > xlo*yd
      if (pl_y_r > pl_x_r) begin
        lon = ylo1_r; lod = yd1_r;
      end else begin
        lon = xlo1_r; lod = xd1_r;
      end
      if (ph_y_r < ph_x_r) begin
        hin = yhi1_r; hid = yd1_r;
      end else begin
        hin = xhi1_r; hid = xd1_r;
      end
    end
  end

  always_comb begin
    lo_le_hi = (a2_r <= b2_r);
    tn = lon2_r[W-1] ? hin2_r : lon2_r;
    td = lon2_r[W-1] ? hid2_r : lod2_r;
    slab_hit = !(c2_r.x_zero && c2_r.y_zero) &&
               (!c2_r.x_zero || c2_r.x_pass) && (!c2_r.y_zero || c2_r.y_pass) &&
               !hin2_r[W-1] && lo_le_hi &&
               (tn > 0) && (tn < $signed({1'b0, td}));
    hit_c = c2_r.endpoint_in || slab_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= q_valid;
      if (adv2) v2_r <= v1_r;
      if (adv)  ov_r <= v2_r;
    end
    if (adv1) begin
      c1_r <= q_cls;
      xlo1_r <= q_xlo_n; xhi1_r <= q_xhi_n; xd1_r <= q_xd;
      ylo1_r <= q_ylo_n; yhi1_r <= q_yhi_n; yd1_r <= q_yd;
      pl_x_r <= PW'(q_xlo_n * $signed({1'b0, q_yd}));
      pl_y_r <= PW'(q_ylo_n * $signed({1'b0, q_xd}));
      ph_x_r <= PW'(q_xhi_n * $signed({1'b0, q_yd}));
      ph_y_r <= PW'(q_yhi_n * $signed({1'b0, q_xd}));
    end
    if (adv2) begin
      c2_r <= c1_r;
      lon2_r <= lon; lod2_r <= lod; hin2_r <= hin; hid2_r <= hid;
      a2_r <= PW'(lon * $signed({1'b0, hid}));
      b2_r <= PW'(hin * $signed({1'b0, lod}));
    end
    if (adv) begin
      hit_r <= hit_c;
      ins_r <= c2_r.endpoint_in;
    end
  end

  assign out_valid = ov_r;
  assign out_hit = hit_r;
  assign out_endpoint_inside = ins_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_endpoint_inside) |-> out_hit) else $error("inside without hit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv) |=> v2_r) else $error("stage two lost item");
endmodule

// ===== rtl/segment_aabb_slab_test_unit.sv =====
// ----------------------------------------------------------------------------
// segment_aabb_slab_test_unit: segment versus axis-aligned rectangle test
// Takes one segment and one rectangle per beat and returns hit flags.
// ----------------------------------------------------------------------------
// One beat in, one beat out, sustained one item per clock while out_stall
// is low. A front stage registers endpoint containment and per-axis slab
// fractions; a two-entry queue sits between it and the back end, which
// spends two multiply stages (choose entry/exit by cross products, then
// compare them) and an output register. A beat passes the front register,
// the queue, both back stages and the output register in that order.
// Results come out in input order; a stalled result holds while new beats
// keep filling the queue and pipeline. All comparisons are exact: slab
// parameters stay fractions and are compared by cross-multiply.
module segment_aabb_slab_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_x,
  input  logic signed [COORD_BITS-1:0] in_box_y,
  input  logic        [COORD_BITS-2:0] in_box_width,
  input  logic        [COORD_BITS-2:0] in_box_height,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic                         out_endpoint_inside
);
  import sast_pkg::*;
  localparam int W  = COORD_BITS + 2;
  localparam int DW = $bits(sast_cls_t) + 4 * W + 2 * (COORD_BITS + 1);

  logic f_valid, f_stall, q_valid, q_stall;
  sast_cls_t f_cls, q_cls;
  logic signed [W-1:0] f_xlo, f_xhi, f_ylo, f_yhi, q_xlo, q_xhi, q_ylo, q_yhi;
  logic [COORD_BITS:0] f_xd, f_yd, q_xd, q_yd;
  logic [DW-1:0] wr_data, rd_data;

  sast_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .sx(in_start_x), .sy(in_start_y), .ex(in_end_x), .ey(in_end_y),
    .bx(in_box_x), .by(in_box_y), .bw(in_box_width), .bh(in_box_height),
    .f_valid, .f_stall, .f_cls,
    .f_xlo_n(f_xlo), .f_xhi_n(f_xhi), .f_xd,
    .f_ylo_n(f_ylo), .f_yhi_n(f_yhi), .f_yd
  );

  // Pack the classified record for the queue.
  assign wr_data = {f_cls, f_xlo, f_xhi, f_xd, f_ylo, f_yhi, f_yd};
  assign {q_cls, q_xlo, q_xhi, q_xd, q_ylo, q_yhi, q_yd} = rd_data;

  sast_queue #(.DW(DW)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data,
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data
  );

  sast_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_cls,
    .q_xlo_n(q_xlo), .q_xhi_n(q_xhi), .q_xd,
    .q_ylo_n(q_ylo), .q_yhi_n(q_yhi), .q_yd,
    .out_valid, .out_stall, .out_hit, .out_endpoint_inside
  );
endmodule
